[rtl/cre_pkg.sv]
// Shared types, character constants and the class function of the range expander.
package cre_pkg;

   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;

   localparam logic [1:0] CLS_NONE  = 2'd0;
   localparam logic [1:0] CLS_LOWER = 2'd1;
   localparam logic [1:0] CLS_UPPER = 2'd2;
   localparam logic [1:0] CLS_DIGIT = 2'd3;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Queued command: optional literal dash, then optional chars lo..hi inclusive.
   typedef struct packed {
      logic       lead_dash;
      logic       body;
      logic [7:0] lo;
      logic [7:0] hi;
      logic       str_last;
   } cmd_type;

   function automatic logic [1:0] char_class(input logic [7:0] c);
      logic [1:0] k;
      k = CLS_NONE;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) k = CLS_LOWER;
      else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) k = CLS_UPPER;
      else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) k = CLS_DIGIT;
      return k;
   endfunction

endpackage

[rtl/cre_front.sv]
// Front end: accepts requests, tracks dash and previous character, builds commands.
module cre_front import cre_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       q_full,
   output logic       push,
   output cmd_type    push_cmd
);

   logic       have_prev_ff, have_prev_in;
   logic       dash_held_ff, dash_held_in;
   logic [7:0] prev_ff, prev_in;
   logic [7:0] start_ff, start_in;

   logic       accept;
   logic       hit;
   logic       hold;
   logic [1:0] start_cls;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign start_cls  = char_class(start_ff);

   always_comb begin
      hit = dash_held_ff && (start_cls != CLS_NONE) &&
            (char_class(req_tdata) == start_cls) && (req_tdata > start_ff);
      hold = !hit && (req_tdata == CHAR_DASH) && have_prev_ff && !req_tlast;

      push_cmd.lead_dash = dash_held_ff && !hit;
      push_cmd.body      = hit || !hold;
      push_cmd.lo        = hit ? (start_ff + 8'd1) : req_tdata;
      push_cmd.hi        = req_tdata;
      push_cmd.str_last  = req_tlast;
      push = accept && (push_cmd.lead_dash || push_cmd.body);

      have_prev_in = have_prev_ff;
      dash_held_in = dash_held_ff;
      prev_in      = prev_ff;
      start_in     = start_ff;
      if (accept) begin
         have_prev_in = !req_tlast;
         dash_held_in = hold;
         prev_in      = req_tdata;
         // a failed range leaves the literal dash as the raw previous character
         if (hold) start_in = (dash_held_ff && !hit) ? CHAR_DASH : prev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         dash_held_ff <= 1'b0;
      end else begin
         have_prev_ff <= have_prev_in;
         dash_held_ff <= dash_held_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff  <= prev_in;
      start_ff <= start_in;
   end

endmodule

[rtl/cre_queue.sv]
// Short command queue between front and back.
module cre_queue import cre_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule

[rtl/cre_back.sv]
// Back end: runs queued commands and emits one character per cycle while the output is not stalled.
module cre_back import cre_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  cmd_type    pop_cmd,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   output logic       rsp_tuser
);

   logic       busy_ff, busy_in;
   logic       cur_dash_ff, cur_dash_in;
   logic       cur_body_ff, cur_body_in;
   logic [7:0] cur_lo_ff, cur_lo_in;
   logic [7:0] cur_hi_ff, cur_hi_in;
   logic       cur_last_ff, cur_last_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic       rsp_run_ff, rsp_run_in;
   logic       rsp_end_ff, rsp_end_in;

   logic       adv;
   logic       fin;

   assign adv = !rsp_valid_ff || rsp_tready;
   assign fin = cur_dash_ff ? !cur_body_ff : (cur_lo_ff == cur_hi_ff);

   always_comb begin
      busy_in      = busy_ff;
      cur_dash_in  = cur_dash_ff;
      cur_body_in  = cur_body_ff;
      cur_lo_in    = cur_lo_ff;
      cur_hi_in    = cur_hi_ff;
      cur_last_in  = cur_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_end_in   = rsp_end_ff;
      pop          = 1'b0;
      if (adv) begin
         rsp_valid_in = busy_ff;
         if (busy_ff) begin
            rsp_char_in = cur_dash_ff ? CHAR_DASH : cur_lo_ff;
            rsp_run_in  = fin;
            rsp_end_in  = fin && cur_last_ff;
            if (cur_dash_ff) cur_dash_in = 1'b0;
            else cur_lo_in = cur_lo_ff + 8'd1;
            if (fin) busy_in = 1'b0;
         end
         // load the next command in the cycle the current one finishes
         if ((!busy_ff || fin) && !q_empty) begin
            pop         = 1'b1;
            busy_in     = 1'b1;
            cur_dash_in = pop_cmd.lead_dash;
            cur_body_in = pop_cmd.body;
            cur_lo_in   = pop_cmd.lo;
            cur_hi_in   = pop_cmd.hi;
            cur_last_in = pop_cmd.str_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cur_dash_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cur_dash_ff  <= cur_dash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_body_ff <= cur_body_in;
      cur_lo_ff   <= cur_lo_in;
      cur_hi_ff   <= cur_hi_in;
      cur_last_ff <= cur_last_in;
      rsp_char_ff <= rsp_char_in;
      rsp_run_ff  <= rsp_run_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_end_ff;
   assign rsp_tuser  = rsp_run_ff;

   a_range_order: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !cur_dash_ff) |-> (cur_lo_ff <= cur_hi_ff))
      else $error("range cursor passed its end");

   a_cmd_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (pop_cmd.lead_dash || pop_cmd.body))
      else $error("command without any result");

endmodule

[rtl/char_range_expander_unit.sv]
// Top level of the character range expander: front, command queue, back.
//
//  channel | dir | tdata          | tlast      | tuser
//  req_    | in  | [7:0] in_char  | in_last    | -
//  rsp_    | out | [7:0] out_char | string_end | run_last
//
// The back end emits a range of n characters as n results, one after another.
// A plain character passes through a queue slot and the back-end registers to the output.
// A dash that is neither first nor last yields nothing until its successor arrives.
// Synchronous reset clears string state, queue pointers and output valid.
// Requests stall only while all QUEUE_DEPTH command slots are full, e.g. behind a long range.
module char_range_expander_unit import cre_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,
   output logic       rsp_tuser    // [0] run_last
);

   logic    q_full;
   logic    q_empty;
   logic    push;
   logic    pop;
   cmd_type push_cmd;
   cmd_type pop_cmd;

   cre_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   cre_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .empty    (q_empty),
      .pop_cmd  (pop_cmd)
   );

   cre_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .pop_cmd    (pop_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[test/char_range_expander_unit_tb.sv]
// Testbench for char_range_expander_unit: directed and random shorthand strings against a built-in expander.
module char_range_expander_unit_tb;
   import cre_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 20;

   typedef enum {PH_DIRECT, PH_FLOW, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD} phase_type;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } shorthand_char_type;

   typedef struct {
      logic [7:0] ch;
      logic       run_last;
      logic       str_end;
   } expanded_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_char
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_char
   logic       rsp_tlast;
   logic       rsp_tuser;           // [0] run_last

   phase_type phase = PH_DIRECT;
   shorthand_char_type pending_q[$];
   expanded_char_type  expanded_q[$];
   shorthand_char_type next_req;
   expanded_char_type  want;
   logic offer_live = 1'b0;
   int   hold_left = 0;
   logic hold_done = 1'b0;
   int   mismatches = 0;
   int   cycles = 0;

   // expander state
   logic [7:0] prev_ch = 8'h00;
   logic       has_prev = 1'b0;
   logic       dash_pending = 1'b0;
   logic [7:0] range_lo = 8'h00;

   char_range_expander_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [1:0] char_kind(input logic [7:0] c);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return CLS_LOWER;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return CLS_UPPER;
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) return CLS_DIGIT;
      return CLS_NONE;
   endfunction

   function automatic int send_idle_pct(input phase_type p);
      if (p == PH_SEND_IDLE) return 79;
      if (p == PH_BOTH) return 27;
      return 0;
   endfunction

   function automatic int recv_stall_pct(input phase_type p);
      if (p == PH_RECV_STALL) return 79;
      if (p == PH_BOTH) return 27;
      return 0;
   endfunction

   task automatic push_expanded(input logic [7:0] c);
      expanded_char_type e;
      e.ch = c;
      e.run_last = 1'b0;
      e.str_end = 1'b0;
      expanded_q.push_back(e);
   endtask

   // Expected output characters for one accepted request.
   task automatic expand_request(input logic [7:0] c, input logic last);
      logic [1:0]        k;
      logic              plain;
      int                first;
      int                v;
      expanded_char_type e;
      first = expanded_q.size();
      plain = 1'b1;
      if (dash_pending) begin
         k = char_kind(range_lo);
         dash_pending = 1'b0;
         if (k != CLS_NONE && char_kind(c) == k && c > range_lo) begin
            for (v = range_lo + 1; v <= c; v++) push_expanded(v[7:0]);
            plain = 1'b0;
         end else begin
            push_expanded(CHAR_DASH);
            prev_ch = CHAR_DASH;
         end
      end
      if (plain) begin
         if (c == CHAR_DASH && has_prev && !last) begin
            dash_pending = 1'b1;
            range_lo = prev_ch;
         end else begin
            push_expanded(c);
         end
      end
      prev_ch = c;
      has_prev = !last;
      if (last) dash_pending = 1'b0;
      if (expanded_q.size() > first) begin
         e = expanded_q[expanded_q.size() - 1];
         e.run_last = 1'b1;
         e.str_end = last;
         expanded_q[expanded_q.size() - 1] = e;
      end
   endtask

   task automatic report_mismatch(input string what, input int exp_val, input int got_val);
      $display("mismatch at cycle %0d: %s expected %0h got %0h", cycles, what, exp_val, got_val);
      mismatches++;
   endtask

   task automatic push_request(input logic [7:0] c, input logic last);
      shorthand_char_type r;
      r.ch = c;
      r.last = last;
      pending_q.push_back(r);
   endtask

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) push_request(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] class_base(input int k);
      if (k == 0) return CHAR_LOWER_A;
      if (k == 1) return CHAR_UPPER_A;
      return CHAR_DIGIT_0;
   endfunction

   // One random string; mostly range shorthand, sometimes raw noise with stray end flags.
   task automatic queue_random_string(output int added);
      logic [7:0] txt[$];
      logic [7:0] base;
      int         len;
      int         span;
      int         k;
      int         kind;
      int         i;
      added = 0;
      if ($urandom_range(0, 99) < 15) begin
         len = $urandom_range(1, 6);
         for (i = 0; i < len; i++)
            push_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         added = len;
      end else begin
         len = $urandom_range(1, 8);
         for (i = 0; i < len; i++) begin
            kind = $urandom_range(0, 9);
            k = $urandom_range(0, 2);
            base = class_base(k);
            span = (k == 2) ? 10 : 26;
            if (kind < 4) begin
               if ($urandom_range(0, 9) == 0) begin
                  txt.push_back(base);
                  txt.push_back(CHAR_DASH);
                  txt.push_back(8'(base + span - 1));
               end else begin
                  txt.push_back(8'(base + $urandom_range(0, span - 1)));
                  txt.push_back(CHAR_DASH);
                  // other class or reversed bounds now and then
                  if ($urandom_range(0, 5) == 0)
                     txt.push_back(8'(class_base($urandom_range(0, 2)) +
                                      $urandom_range(0, 9)));
                  else
                     txt.push_back(8'(base + $urandom_range(0, span - 1)));
               end
            end else if (kind < 6) begin
               txt.push_back(CHAR_DASH);
            end else if (kind < 8) begin
               txt.push_back(8'(base + $urandom_range(0, span - 1)));
            end else begin
               txt.push_back(8'($urandom_range(0, 255)));
            end
         end
         foreach (txt[j]) push_request(txt[j], j == txt.size() - 1);
         added = txt.size();
      end
   endtask

   task automatic queue_random(input int count);
      int total;
      int n;
      total = 0;
      while (total < count) begin
         queue_random_string(n);
         total += n;
      end
   endtask

   task automatic drain();
      while (pending_q.size() != 0 || offer_live || expanded_q.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expand_request(req_tdata, req_tlast);
            offer_live = 1'b0;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct(phase)) begin
               next_req = pending_q.pop_front();
               req_tdata <= next_req.ch;
               req_tlast <= next_req.last;
               req_tvalid <= 1'b1;
               offer_live = 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (phase == PH_HOLD && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expanded_q.size() == 0) begin
               report_mismatch("unexpected result, char", 0, rsp_tdata);
            end else begin
               want = expanded_q.pop_front();
               if (rsp_tdata !== want.ch) report_mismatch("out_char", want.ch, rsp_tdata);
               if (rsp_tuser !== want.run_last)
                  report_mismatch("run_last", want.run_last, rsp_tuser);
               if (rsp_tlast !== want.str_end)
                  report_mismatch("string_end", want.str_end, rsp_tlast);
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct(phase));
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("char_range_expander_unit test failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      push_text("-");       // lone dash: both first and last
      push_text("a-z");     // widest range
      push_text("-x-");     // dash at string start and end
      push_text("z-a");     // end not above start
      push_text("a-Z");     // end in another class
      push_text("A-B-C");   // chained ranges
      push_text("0-9");
      push_text("5--7");    // dash as successor, held again
      drain();

      phase <= PH_FLOW;
      queue_random(50);
      drain();
      phase <= PH_SEND_IDLE;
      queue_random(50);
      drain();
      phase <= PH_RECV_STALL;
      queue_random(60);
      drain();
      phase <= PH_BOTH;
      queue_random(70);
      drain();
      phase <= PH_HOLD;
      queue_random(55);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("char_range_expander_unit test passed");
      end else begin
         $display("char_range_expander_unit test failed");
      end
      $finish;
   end

endmodule
